// ===== design/bls_pkg.sv =====
package bls_pkg;

	// Coordinate width and the signed width of the decision term
	localparam int COORD_BITS = 11;
	localparam int DEC_BITS   = COORD_BITS + 3;
	localparam int DEC_PAD    = DEC_BITS - COORD_BITS;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	// Input transaction
	typedef struct packed {
		logic   command;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} cmd_in_t;

	// Result transaction
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   pixel_valid;
		logic   last_pixel;
	} pix_out_t;

	// Classified command passed from front to back
	typedef struct packed {
		logic   command;
		coord_t start_x;
		coord_t start_y;
		coord_t major_end;
		dec_t   decision;
		dec_t   inc_straight;
		dec_t   inc_diagonal;
		logic   minor_down;
		logic   x_major;
		logic   last;
	} ucmd_t;

endpackage

// ===== design/bresenham_line_stepper.sv =====
// Accepted transactions reach the result ports (empty low) via queue and buffer.
// Throughput: one transaction per cycle while the result buffer has room;
// the back end executes one classified command per cycle from a two-entry
// queue into a two-entry buffer.
// Reset (arst_n low, asynchronous): queues empty, no line active.
module bresenham_line_stepper (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bls_pkg::cmd_in_t  item,
	output logic              empty,
	input  logic              pop,
	output bls_pkg::pix_out_t result
);
	import bls_pkg::*;

	ucmd_t ucmd_in, ucmd_head;
	logic  q_valid, q_pop;

	// Front: classify incoming command
	bls_front u_front (
		.item (item),
		.ucmd (ucmd_in)
	);

	// Queue between front and back
	bls_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (ucmd_in),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (ucmd_head),
		.valid   (q_valid)
	);

	// Back: step the line and buffer results
	bls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (ucmd_head),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== design/bls_front.sv =====
module bls_front (
	input  bls_pkg::cmd_in_t item,
	output bls_pkg::ucmd_t   ucmd
);
	import bls_pkg::*;

	coord_t dx, dy, dmaj, dmin;
	coord_t sx, sy, fx, fy, maj_start, maj_end;
	logic   xmaj, swap;
	dec_t   dmaj_e, dmin_e;

	// Absolute deltas and axis choice; a tie goes y-major
	always_comb begin
		dx   = (item.x_start > item.x_end) ? item.x_start - item.x_end
		                                   : item.x_end - item.x_start;
		dy   = (item.y_start > item.y_end) ? item.y_start - item.y_end
		                                   : item.y_end - item.y_start;
		xmaj = dx > dy;
		swap = xmaj ? (item.x_start > item.x_end) : (item.y_start > item.y_end);
	end

	// Start at the endpoint with the smaller major coordinate
	always_comb begin
		sx        = swap ? item.x_end   : item.x_start;
		sy        = swap ? item.y_end   : item.y_start;
		fx        = swap ? item.x_start : item.x_end;
		fy        = swap ? item.y_start : item.y_end;
		maj_start = xmaj ? sx : sy;
		maj_end   = xmaj ? fx : fy;
		dmaj      = xmaj ? dx : dy;
		dmin      = xmaj ? dy : dx;
		dmaj_e    = dec_t'({{DEC_PAD{1'b0}}, dmaj});
		dmin_e    = dec_t'({{DEC_PAD{1'b0}}, dmin});
	end

	// Classified command
	always_comb begin
		ucmd.command      = item.command;
		ucmd.start_x      = sx;
		ucmd.start_y      = sy;
		ucmd.major_end    = maj_end;
		ucmd.decision     = (dmin_e <<< 1) - dmaj_e;
		ucmd.inc_straight = dmin_e <<< 1;
		ucmd.inc_diagonal = (dmin_e - dmaj_e) <<< 1;
		ucmd.minor_down   = xmaj ? (fy < sy) : (fx < sx);
		ucmd.x_major      = xmaj;
		ucmd.last         = maj_start == maj_end;
	end

endmodule

// ===== design/bls_cmd_fifo.sv =====
module bls_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  bls_pkg::ucmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output bls_pkg::ucmd_t rd_data,
	output logic           valid
);
	import bls_pkg::*;

	ucmd_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full    = cnt_q == 2'd2;
	assign valid   = cnt_q != 2'd0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== design/bls_back.sv =====
module bls_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  bls_pkg::ucmd_t   cmd,
	output logic             cmd_pop,
	output bls_pkg::pix_out_t result,
	output logic             empty,
	input  logic             pop
);
	import bls_pkg::*;

	// Line state
	coord_t cur_x_q, cur_y_q, major_end_q;
	dec_t   dec_q, inc_s_q, inc_d_q;
	logic   minor_down_q, x_major_q, act_q;

	// Next state
	coord_t cur_x_d, cur_y_d, major_end_d;
	dec_t   dec_d, inc_s_d, inc_d_d;
	logic   minor_down_d, x_major_d, act_d;
	pix_out_t res_d;

	coord_t maj_cur, maj_nxt, min_cur, min_nxt;
	logic   dec_neg, step_last;

	// Result buffer
	pix_out_t   res_q [2];
	logic       res_wp_q, res_rp_q;
	logic [1:0] res_cnt_q;
	logic       res_push, res_pop;

	assign res_push = cmd_valid && (res_cnt_q != 2'd2);
	assign res_pop  = pop && !empty;
	assign cmd_pop  = res_push;
	assign empty    = res_cnt_q == 2'd0;
	assign result   = res_q[res_rp_q];

	// One step along the major axis
	always_comb begin
		dec_neg   = dec_q[DEC_BITS-1];
		maj_cur   = x_major_q ? cur_x_q : cur_y_q;
		min_cur   = x_major_q ? cur_y_q : cur_x_q;
		maj_nxt   = maj_cur + coord_t'(1);
		if (dec_neg) min_nxt = min_cur;
		else if (minor_down_q) min_nxt = min_cur - coord_t'(1);
		else min_nxt = min_cur + coord_t'(1);
		step_last = maj_nxt == major_end_q;
	end

	// Execute the head command
	always_comb begin
		cur_x_d      = cur_x_q;
		cur_y_d      = cur_y_q;
		major_end_d  = major_end_q;
		dec_d        = dec_q;
		inc_s_d      = inc_s_q;
		inc_d_d      = inc_d_q;
		minor_down_d = minor_down_q;
		x_major_d    = x_major_q;
		act_d        = act_q;
		res_d        = '0;
		if (cmd.command == CMD_LOAD) begin
			cur_x_d      = cmd.start_x;
			cur_y_d      = cmd.start_y;
			major_end_d  = cmd.major_end;
			dec_d        = cmd.decision;
			inc_s_d      = cmd.inc_straight;
			inc_d_d      = cmd.inc_diagonal;
			minor_down_d = cmd.minor_down;
			x_major_d    = cmd.x_major;
			act_d        = !cmd.last;
			res_d        = '{cmd.start_x, cmd.start_y, 1'b1, cmd.last};
		end else if (act_q) begin
			cur_x_d = x_major_q ? maj_nxt : min_nxt;
			cur_y_d = x_major_q ? min_nxt : maj_nxt;
			dec_d   = dec_q + (dec_neg ? inc_s_q : inc_d_q);
			act_d   = !step_last;
			res_d   = '{cur_x_d, cur_y_d, 1'b1, step_last};
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			major_end_q  <= '0;
			dec_q        <= '0;
			inc_s_q      <= '0;
			inc_d_q      <= '0;
			minor_down_q <= 1'b0;
			x_major_q    <= 1'b0;
			act_q        <= 1'b0;
		end else if (res_push) begin
			cur_x_q      <= cur_x_d;
			cur_y_q      <= cur_y_d;
			major_end_q  <= major_end_d;
			dec_q        <= dec_d;
			inc_s_q      <= inc_s_d;
			inc_d_q      <= inc_d_d;
			minor_down_q <= minor_down_d;
			x_major_q    <= x_major_d;
			act_q        <= act_d;
		end
	end

	// Result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wp_q  <= 1'b0;
			res_rp_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) res_wp_q <= !res_wp_q;
			if (res_pop) res_rp_q <= !res_rp_q;
			if (res_push && !res_pop) res_cnt_q <= res_cnt_q + 2'd1;
			else if (res_pop && !res_push) res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// Result buffer storage
	always_ff @(posedge clk) begin
		if (res_push) res_q[res_wp_q] <= res_d;
	end

`ifndef SYNTHESIS
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_d.last_pixel |=> !act_q)
		else $error("line still active after last pixel");

	a_mid_keeps_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_d.pixel_valid && !res_d.last_pixel |=> act_q)
		else $error("line dropped before last pixel");

	a_idle_step_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !act_q && (cmd.command == CMD_STEP) |-> !res_d.pixel_valid)
		else $error("pixel emitted with no line active");

	a_res_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result buffer count out of range");
`endif

endmodule
